@@ rtl/signed_integer_text_parser_core_assert.svh @@
// Assertion macros for the signed integer text parser.
// Used by files that hold concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SIGNED_INTEGER_TEXT_PARSER_CORE_ASSERT_SVH
`define SIGNED_INTEGER_TEXT_PARSER_CORE_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define SITP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SITP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/sitp_pkg.sv @@
// Shared types and constants for the signed integer text parser.
// No dependencies; imported by the step logic, the top level and the checker.
package sitp_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned RadixWidth = 6;

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerZ  = 8'h7A;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperZ  = 8'h5A;
  localparam logic [7:0] CharLowerX  = 8'h78;
  localparam logic [7:0] CharUpperX  = 8'h58;
  localparam logic [7:0] LetterBase  = 8'd10;

  localparam logic [RadixWidth-1:0] RadixAuto = 6'd0;
  localparam logic [RadixWidth-1:0] RadixDec  = 6'd10;
  localparam logic [RadixWidth-1:0] RadixHex  = 6'd16;
  localparam logic [RadixWidth-1:0] RadixMax  = 6'd36;

  typedef enum logic [1:0] {
    PhSpace,
    PhSigned,
    PhZero,
    PhDigits
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic [ValueWidth-1:0]  mag;
    logic                   neg;
    logic [RadixWidth-1:0]  radix;
    logic [CountWidth-1:0]  count;
  } state_t;

endpackage

@@ rtl/signed_integer_text_parser_core.sv @@
// Top level of the signed integer text parser: parse state and result register.
// Depends on sitp_pkg and sitp_step.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   input    | in        | in_valid_i / in_stall_o | text_char_i
//   output   | out       | out_valid_o/ out_stall_i| parsed_value_o, chars_used_o
//   config   | in        | cfg_we_i                | cfg_wdata_i (number_base)
//
// One character is taken per cycle unless stalled; the multiply-add in sitp_step
// sets the path. A taken terminator's result is at out_valid_o the next cycle.
// Input stalls only while a result waits in the output register and is stalled.
// Reset clears the parse state, the base register and the output valid flag.
module signed_integer_text_parser_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sitp_pkg::RadixWidth-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [7:0]                             text_char_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [sitp_pkg::ValueWidth-1:0] parsed_value_o,
  output logic [sitp_pkg::CountWidth-1:0]        chars_used_o
);
  import sitp_pkg::*;

  state_t                  state_q, state_d, state_next;
  logic [RadixWidth-1:0]   base_q;
  logic                    emit;
  logic                    in_xfer;
  logic                    out_valid_q, out_valid_d;
  logic [ValueWidth-1:0]   value_q, value_d;
  logic [CountWidth-1:0]   used_q, used_d;

  sitp_step u_step (
    .state_i (state_q),
    .char_i  (text_char_i),
    .base_i  (base_q),
    .state_o (state_next),
    .emit_o  (emit)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign state_d    = in_xfer ? state_next : state_q;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    value_d     = value_q;
    used_d      = used_q;
    if (in_xfer && emit) begin
      out_valid_d = 1'b1;
      value_d     = state_q.neg ? ({ValueWidth{1'b0}} - state_q.mag) : state_q.mag;
      used_d      = state_q.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PhSpace, mag: '0, neg: 1'b0, radix: RadixAuto, count: '0};
      base_q      <= RadixAuto;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    used_q  <= used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign parsed_value_o = value_q;
  assign chars_used_o   = used_q;

endmodule

@@ rtl/sitp_step.sv @@
// Per-character transition of the parser: decode, digit multiply-add, next state.
// Depends on sitp_pkg.
module sitp_step (
  input  sitp_pkg::state_t                       state_i,
  input  logic [7:0]                             char_i,
  input  logic [sitp_pkg::RadixWidth-1:0]        base_i,
  output sitp_pkg::state_t                       state_o,
  output logic                                   emit_o
);
  import sitp_pkg::*;

  logic                    is_ws;
  logic                    is_minus;
  logic                    is_plus;
  logic                    is_x;
  logic                    is_zero;
  logic                    dvalid;
  logic [7:0]              dtmp;
  logic [RadixWidth-1:0]   dval;
  logic [RadixWidth-1:0]   base_clip;
  logic [RadixWidth-1:0]   judge_r;
  logic [RadixWidth-1:0]   digit_r;
  logic                    auto_case;
  logic                    take_ws;
  logic                    take_sign;
  logic                    take_x;
  logic                    take_zero;
  logic                    take_digit;
  logic [ValueWidth+RadixWidth-1:0] prod;
  logic [CountWidth-1:0]   count_inc;
  phase_e                  phase_d;

  assign is_ws    = (char_i == CharSpace) || (char_i == CharTab) ||
                    (char_i == CharNewline) || (char_i == CharCr);
  assign is_minus = (char_i == CharMinus);
  assign is_plus  = (char_i == CharPlus);
  assign is_x     = (char_i == CharLowerX) || (char_i == CharUpperX);
  assign is_zero  = (char_i == CharZero);

  always_comb begin
    dtmp   = 8'd0;
    dvalid = 1'b1;
    if (char_i inside {[CharZero:CharNine]}) begin
      dtmp = char_i - CharZero;
    end else if (char_i inside {[CharLowerA:CharLowerZ]}) begin
      dtmp = char_i - CharLowerA + LetterBase;
    end else if (char_i inside {[CharUpperA:CharUpperZ]}) begin
      dtmp = char_i - CharUpperA + LetterBase;
    end else begin
      dvalid = 1'b0;
    end
  end
  assign dval = dtmp[RadixWidth-1:0];

  assign base_clip = (base_i > RadixMax) ? RadixMax : base_i;

  always_comb begin
    case (state_i.phase)
      PhSpace: judge_r = base_clip;
      PhZero:  judge_r = RadixDec;
      default: judge_r = state_i.radix;
    endcase
  end

  assign take_ws   = (state_i.phase == PhSpace) && is_ws;
  assign take_sign = (state_i.phase == PhSpace) && (is_minus || is_plus);
  assign take_x    = (state_i.phase == PhZero) && is_x;
  assign auto_case = ((state_i.phase == PhSpace) || (state_i.phase == PhSigned)) &&
                     (judge_r == RadixAuto) && !take_ws && !take_sign;
  assign take_zero = auto_case && is_zero;
  assign digit_r   = auto_case ? RadixDec : judge_r;
  assign take_digit = !take_ws && !take_sign && !take_x && !take_zero &&
                      dvalid && (dval < digit_r);
  assign emit_o    = !(take_ws || take_sign || take_x || take_zero || take_digit);

  assign prod      = state_i.mag * digit_r;
  assign count_inc = (&state_i.count) ? state_i.count : state_i.count + 1'b1;

  // Next phase.
  always_comb begin
    phase_d = state_i.phase;
    if (emit_o) begin
      phase_d = PhSpace;
    end else if (take_sign) begin
      phase_d = PhSigned;
    end else if (take_zero) begin
      phase_d = PhZero;
    end else if (take_x || take_digit) begin
      phase_d = PhDigits;
    end
  end

  // Datapath.
  always_comb begin
    state_o       = state_i;
    state_o.phase = phase_d;
    if (emit_o) begin
      state_o.mag   = '0;
      state_o.neg   = 1'b0;
      state_o.radix = RadixAuto;
      state_o.count = '0;
    end else begin
      state_o.count = count_inc;
      if (take_sign) begin
        state_o.radix = base_clip;
        state_o.neg   = is_minus;
      end else if (take_x) begin
        state_o.radix = RadixHex;
      end else if (take_zero) begin
        state_o.radix = RadixAuto;
      end else if (take_digit) begin
        state_o.radix = digit_r;
        state_o.mag   = prod[ValueWidth-1:0] + {{(ValueWidth-RadixWidth){1'b0}}, dval};
      end
    end
  end

endmodule

@@ rtl/sitp_checker.sv @@
// Port-level checks for the signed integer text parser, bound to the top level.
// Depends on sitp_pkg and signed_integer_text_parser_core_assert.svh.
`include "signed_integer_text_parser_core_assert.svh"

module sitp_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sitp_pkg::RadixWidth-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_o,
  input  logic [7:0]                             text_char_i,
  input  logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic signed [sitp_pkg::ValueWidth-1:0] parsed_value_o,
  input  logic [sitp_pkg::CountWidth-1:0]        chars_used_o
);
  import sitp_pkg::*;

  `SITP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output dropped while stalled")
  `SITP_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(parsed_value_o) && $stable(chars_used_o), "output payload changed while stalled")
  `SITP_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a waiting result")
  `SITP_ASSERT(a_result_source, out_valid_o && !$past(out_valid_o && out_stall_i) |-> $past(in_valid_i && !in_stall_o), "result without an input transfer")

endmodule

bind signed_integer_text_parser_core sitp_checker u_sitp_checker (.*);

@@ verif/signed_integer_text_parser_core_monitor.sv @@
`timescale 1ns / 100ps
// Transfer monitor for signed_integer_text_parser_core: tracks base writes and
// accepted characters, predicts each parse result and compares result transfers.
// Depends on sitp_pkg.
module signed_integer_text_parser_core_monitor (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sitp_pkg::RadixWidth-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic [7:0]                             text_char_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic signed [sitp_pkg::ValueWidth-1:0] parsed_value_i,
  input  logic [sitp_pkg::CountWidth-1:0]        chars_used_i,
  output int                                     fail_count_o,
  output int                                     in_flight_o
);
  import sitp_pkg::*;

  typedef struct {
    logic signed [ValueWidth-1:0] value;
    logic [CountWidth-1:0]        used;
  } parse_result_t;

  phase_e                phase_q;
  logic [ValueWidth-1:0] mag_q;
  logic                  neg_q;
  logic [RadixWidth-1:0] radix_q;
  logic [CountWidth-1:0] used_q;
  logic [RadixWidth-1:0] base_q;
  parse_result_t         expected_numbers[$];
  parse_result_t         want;
  int                    errors = 0;

  task automatic clear_parse();
    phase_q = PhSpace;
    mag_q   = '0;
    neg_q   = 1'b0;
    radix_q = RadixAuto;
    used_q  = '0;
  endtask

  task automatic count_char();
    if (used_q != '1) used_q++;
  endtask

  task automatic parse_char(input logic [7:0] c);
    int            digit;
    logic          judge_sign;
    logic          judge_digit;
    logic          taken;
    parse_result_t res;
    judge_sign  = 1'b0;
    judge_digit = 1'b0;
    taken       = 1'b0;
    digit       = -1;
    if (c >= CharZero && c <= CharNine) begin
      digit = int'(c - CharZero);
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      digit = int'(c - CharLowerA) + int'(LetterBase);
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      digit = int'(c - CharUpperA) + int'(LetterBase);
    end
    case (phase_q)
      PhSpace: begin
        if (c == CharSpace || c == CharTab || c == CharNewline || c == CharCr) begin
          count_char();
          taken = 1'b1;
        end else begin
          radix_q = (base_q > RadixMax) ? RadixMax : base_q;
          if (c == CharMinus || c == CharPlus) begin
            neg_q   = (c == CharMinus);
            phase_q = PhSigned;
            count_char();
            taken   = 1'b1;
          end else begin
            judge_sign = 1'b1;
          end
        end
      end
      PhSigned: judge_sign = 1'b1;
      PhZero: begin
        if (c == CharLowerX || c == CharUpperX) begin
          radix_q = RadixHex;
          phase_q = PhDigits;
          count_char();
          taken   = 1'b1;
        end else begin
          radix_q     = RadixDec;
          mag_q       = '0;
          judge_digit = 1'b1;
        end
      end
      default: judge_digit = 1'b1;
    endcase
    if (judge_sign) begin
      if (radix_q == RadixAuto && c == CharZero) begin
        phase_q = PhZero;
        count_char();
        taken   = 1'b1;
      end else begin
        if (radix_q == RadixAuto) radix_q = RadixDec;
        judge_digit = 1'b1;
      end
    end
    if (judge_digit && digit >= 0 && digit < int'(radix_q)) begin
      mag_q   = mag_q * ValueWidth'(radix_q) + ValueWidth'(digit);
      phase_q = PhDigits;
      count_char();
      taken   = 1'b1;
    end
    if (!taken) begin
      res.value = neg_q ? -mag_q : mag_q;
      res.used  = used_q;
      expected_numbers.push_back(res);
      clear_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      base_q = RadixAuto;
      expected_numbers.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result transfer: parsed_value %0d, chars_used %0d",
                 parsed_value_i, chars_used_i);
          errors++;
        end else begin
          want = expected_numbers.pop_front();
          if (parsed_value_i !== want.value) begin
            $error("parsed_value: expected %0d, got %0d", want.value, parsed_value_i);
            errors++;
          end
          if (chars_used_i !== want.used) begin
            $error("chars_used: expected %0d, got %0d", want.used, chars_used_i);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(text_char_i);
      if (cfg_we_i) base_q = cfg_wdata_i;
    end
    fail_count_o <= errors;
    in_flight_o  <= expected_numbers.size();
  end

endmodule

@@ verif/signed_integer_text_parser_core_test.sv @@
`timescale 1ns / 100ps
// Top of the signed_integer_text_parser_core testbench: clock, reset, character
// and base stimulus, result-side stalls and the verdict.
// Depends on sitp_pkg, the core and signed_integer_text_parser_core_monitor.
module signed_integer_text_parser_core_test;
  import sitp_pkg::*;

  localparam int CycleLimit    = 1_000_000;
  localparam int HoldOffCycles = 300;
  localparam int RandomItems   = 850;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [RadixWidth-1:0]        cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic [7:0]                   text_char_i = '0;
  logic                         out_stall_i = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic signed [ValueWidth-1:0] parsed_value_o;
  logic [CountWidth-1:0]        chars_used_o;

  int                    fail_count;
  int                    in_flight;
  int                    cycle_count  = 0;
  int                    sent_chars   = 0;
  bit                    quiet_phase  = 1'b0;
  bit                    hold_off_req = 1'b0;
  logic [RadixWidth-1:0] base_now     = RadixAuto;

  signed_integer_text_parser_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_char_i   (text_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .parsed_value_o(parsed_value_o),
    .chars_used_o  (chars_used_o)
  );

  signed_integer_text_parser_core_monitor monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .text_char_i   (text_char_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .parsed_value_i(parsed_value_o),
    .chars_used_i  (chars_used_o),
    .fail_count_o  (fail_count),
    .in_flight_o   (in_flight)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] digit_char(input int radix);
    int v;
    v = $urandom_range(0, radix - 1);
    if (v < 10) return CharZero + 8'(v);
    return ($urandom_range(0, 1) ? CharUpperA : CharLowerA) + 8'(v - 10);
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic set_base(input logic [RadixWidth-1:0] v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    base_now     = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_token();
    int   pick;
    int   len;
    int   radix;
    logic hex_prefix;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: send_char(CharSpace);
          1: send_char(CharTab);
          2: send_char(CharNewline);
          default: send_char(CharCr);
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_char(CharMinus);
      end else if (pick < 45) begin
        send_char(CharPlus);
      end else if (pick < 50) begin
        send_char(CharMinus);
        send_char(CharPlus);
      end
      hex_prefix = (base_now == RadixAuto) ? ($urandom_range(0, 2) == 0)
                                           : ($urandom_range(0, 9) == 0);
      if (hex_prefix) begin
        send_char(CharZero);
        send_char($urandom_range(0, 1) ? CharUpperX : CharLowerX);
      end
      if (base_now == RadixAuto) begin
        radix = hex_prefix ? int'(RadixHex) : int'(RadixDec);
      end else begin
        radix = (base_now > RadixMax) ? int'(RadixMax) : int'(base_now);
      end
      if (radix == int'(RadixHex) && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1)) begin
          repeat (16) send_char($urandom_range(0, 1) ? "F" : "f");
        end else begin
          send_char("8");
          repeat (15) send_char(CharZero);
        end
      end else begin
        pick = $urandom_range(0, 99);
        len  = (pick < 10) ? 0 : (pick < 80) ? $urandom_range(1, 6) : $urandom_range(14, 24);
        repeat (len) send_char(digit_char(radix));
      end
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : receiver
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        n = idle_len();
        out_stall_i <= (n > 0);
        repeat ((n > 0) ? n : $urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("signed_integer_text_parser_core_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    int phase_idx;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_base(RadixAuto);
    send_char(CharSpace);
    send_char(CharTab);
    send_char(CharNewline);
    send_char(CharCr);
    send_text("+7!");
    send_text("-0Xg");
    send_text("09x");
    send_text("-+");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("  ");
    set_base(RadixHex);
    send_text("ff;");
    set_base(RadixDec);
    send_text("-1");
    set_base(6'd2);
    send_text("9;");
    set_base(RadixHex);
    send_text("0x;");
    set_base(6'd1);
    send_text("01;");
    set_base(RadixMax);
    send_text("zZ9?");
    set_base(6'd63);
    send_text("Zz.");

    random_start = sent_chars;
    phase_idx    = 0;
    while (sent_chars < random_start + RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: set_base(RadixAuto);
        3:       set_base(RadixDec);
        4:       set_base(RadixHex);
        5:       set_base(6'd1);
        6:       set_base(RadixMax);
        7:       set_base(6'd63);
        default: set_base(6'($urandom_range(0, 63)));
      endcase
      quiet_phase = ($urandom_range(0, 3) == 0);
      if (phase_idx == 2) begin
        quiet_phase  = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat ($urandom_range(8, 20)) send_token();
      phase_idx++;
    end

    in_valid_i <= 1'b0;
    quiet_phase = 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && in_flight == 0) begin
      $display("signed_integer_text_parser_core_test: done, clean");
    end else begin
      $display("signed_integer_text_parser_core_test: done, errors");
    end
    $finish;
  end

endmodule
